// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, prop)
`define ASSERT_RST(label, clk, prop)
`endif
`endif

// File: hw/rtl/fau_pkg.sv
// Package with types, constants and codes of the fraction arithmetic unit.
`default_nettype none
package fau_pkg;
  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ProdWidth = 2 * OperandWidth;
  localparam int unsigned NumWidth = 33;
  localparam int unsigned DenWidth = 32;
  localparam int unsigned MagWidth = OperandWidth;
  localparam int unsigned CntWidth = $clog2(MagWidth + 2);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_RED = 3'd4,
    OP_MAX = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_GCD,
    ST_DIV,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic is_reduce;
    logic gcd_done;
    logic div_done;
  } stat_t;
endpackage
`default_nettype wire

// File: hw/rtl/fau_datapath.sv
// Datapath: products, sums, the max compare, subtractive gcd and restoring division.
`default_nettype none
module fau_datapath (
  input  wire logic                          clk,
  input  wire fau_pkg::cmd_t                 cmd,
  output fau_pkg::stat_t                     stat,
  input  wire logic [2:0]                    opcode,
  input  wire logic [fau_pkg::OperandWidth-1:0] a_num,
  input  wire logic [fau_pkg::OperandWidth-1:0] a_den,
  input  wire logic [fau_pkg::OperandWidth-1:0] b_num,
  input  wire logic [fau_pkg::OperandWidth-1:0] b_den,
  output logic [fau_pkg::NumWidth-1:0]       res_num,
  output logic [fau_pkg::DenWidth-1:0]       res_den,
  output logic                               status
);
  localparam int unsigned W = fau_pkg::OperandWidth;
  localparam int unsigned P = fau_pkg::ProdWidth;

  logic [2:0] op;
  logic signed [W-1:0] an, ad, bn, bd;
  logic signed [P-1:0] p0, p1, p2, p3;
  logic [W-1:0] gx, gy, mag_n, mag_d;
  logic [W-1:0] qn, qd, rmn, rmd;
  logic [fau_pkg::CntWidth-1:0] cnt;
  logic signed [W-1:0] pan, pbn;
  logic signed [W:0] pad, pbd, pan_x, pbn_x;
  logic signed [2*W+1:0] lhs, rhs;
  logic [W:0] trn, trd;
  logic signed [P:0] sum_add, sum_sub;

  always_comb begin
    pan_x = ad[W-1] ? -{an[W-1], an} : {an[W-1], an};
    pad   = ad[W-1] ? -{ad[W-1], ad} : {ad[W-1], ad};
    pbn_x = bd[W-1] ? -{bn[W-1], bn} : {bn[W-1], bn};
    pbd   = bd[W-1] ? -{bd[W-1], bd} : {bd[W-1], bd};
    pan = an;
    pbn = bn;
    trn = {rmn, qn[W-1]} - {1'b0, gx};
    trd = {rmd, qd[W-1]} - {1'b0, gx};
    sum_add = {p0[P-1], p0} + {p1[P-1], p1};
    sum_sub = {p0[P-1], p0} - {p1[P-1], p1};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= opcode;
      an <= a_num;
      ad <= a_den;
      bn <= b_num;
      bd <= b_den;
      mag_n <= a_num[W-1] ? -a_num : a_num;
      mag_d <= a_den[W-1] ? -a_den : a_den;
      gx <= a_num[W-1] ? -a_num : a_num;
      gy <= a_den[W-1] ? -a_den : a_den;
    end
    if (cmd.mul) begin
      unique case (op)
        fau_pkg::OP_MUL: begin
          p0 <= P'(an * bn);
          p1 <= P'(an * bn);
          p2 <= P'(ad * bd);
        end
        fau_pkg::OP_DIV: begin
          p0 <= P'(an * bd);
          p1 <= P'(an * bd);
          p2 <= P'(ad * bn);
        end
        default: begin
          p0 <= P'(an * bd);
          p1 <= P'(ad * bn);
          p2 <= P'(ad * bd);
        end
      endcase
      lhs <= (2*W+2)'(pan_x * pbd);
      rhs <= (2*W+2)'(pbn_x * pad);
    end
    if (cmd.gcd_step) begin
      if (gx == '0) begin
        gx <= gy;
        gy <= '0;
      end else if (gy != '0) begin
        if (gx > gy) gx <= gx - gy;
        else gy <= gy - gx;
      end
    end
    if (cmd.div_init) begin
      qn <= mag_n;
      qd <= mag_d;
      rmn <= '0;
      rmd <= '0;
      cnt <= '0;
    end
    if (cmd.div_step) begin
      cnt <= cnt + 1'b1;
      if (!trn[W]) begin
        rmn <= trn[W-1:0];
        qn <= {qn[W-2:0], 1'b1};
      end else begin
        rmn <= {rmn[W-2:0], qn[W-1]};
        qn <= {qn[W-2:0], 1'b0};
      end
      if (!trd[W]) begin
        rmd <= trd[W-1:0];
        qd <= {qd[W-2:0], 1'b1};
      end else begin
        rmd <= {rmd[W-2:0], qd[W-1]};
        qd <= {qd[W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      status <= 1'b0;
      unique case (op)
        fau_pkg::OP_ADD: begin
          res_num <= fau_pkg::NumWidth'(sum_add);
          res_den <= fau_pkg::DenWidth'(p2);
          status <= (p2 == '0);
        end
        fau_pkg::OP_SUB: begin
          res_num <= fau_pkg::NumWidth'(sum_sub);
          res_den <= fau_pkg::DenWidth'(p2);
          status <= (p2 == '0);
        end
        fau_pkg::OP_MUL, fau_pkg::OP_DIV: begin
          res_num <= fau_pkg::NumWidth'(p0);
          res_den <= fau_pkg::DenWidth'(p2);
          status <= (p2 == '0);
        end
        fau_pkg::OP_RED: begin
          if (gx == '0) begin
            res_num <= '0;
            res_den <= '0;
            status <= 1'b1;
          end else begin
            res_num <= an[W-1] ? -fau_pkg::NumWidth'(qn) : fau_pkg::NumWidth'(qn);
            res_den <= ad[W-1] ? -fau_pkg::DenWidth'(qd) : fau_pkg::DenWidth'(qd);
            status <= (qd == '0);
          end
        end
        fau_pkg::OP_MAX: begin
          if (lhs > rhs) begin
            res_num <= fau_pkg::NumWidth'(pan);
            res_den <= fau_pkg::DenWidth'(ad);
            status <= (ad == '0);
          end else begin
            res_num <= fau_pkg::NumWidth'(pbn);
            res_den <= fau_pkg::DenWidth'(bd);
            status <= (bd == '0);
          end
        end
        default: begin
          res_num <= '0;
          res_den <= '0;
          status <= 1'b1;
        end
      endcase
    end
  end

  assign stat.is_reduce = (op == fau_pkg::OP_RED);
  assign stat.gcd_done = (gx == '0) || (gy == '0);
  assign stat.div_done = (cnt == fau_pkg::CntWidth'(W - 1)) && cmd.div_step;
endmodule
`default_nettype wire

// File: hw/rtl/fau_ctrl.sv
// Controller state machine sequencing the datapath and both handshakes.
`default_nettype none
module fau_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire fau_pkg::stat_t stat,
  output fau_pkg::cmd_t       cmd
);
  fau_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= fau_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      fau_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = fau_pkg::ST_MUL;
        end
      end
      fau_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
        state_next = stat.is_reduce ? fau_pkg::ST_GCD : fau_pkg::ST_FIN;
      end
      fau_pkg::ST_GCD: begin
        if (stat.gcd_done) begin
          cmd.gcd_step = 1'b1;
          cmd.div_init = 1'b1;
          state_next = fau_pkg::ST_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      fau_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) begin
          state_next = fau_pkg::ST_FIN;
        end
      end
      fau_pkg::ST_FIN: begin
        state_next = fau_pkg::ST_DONE;
      end
      fau_pkg::ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.load = 1'b1;
            state_next = fau_pkg::ST_MUL;
          end else begin
            state_next = fau_pkg::ST_IDLE;
          end
        end
      end
      default: state_next = fau_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hw/rtl/fau_result.sv
// Result register stage that launches the finish command once per item.
`default_nettype none
module fau_result (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire fau_pkg::cmd_t cmd_in,
  input  wire logic          enter_done,
  output fau_pkg::cmd_t      cmd_out
);
  logic fin;

  always_ff @(posedge clk) begin
    if (rst) fin <= 1'b0;
    else fin <= enter_done;
  end

  always_comb begin
    cmd_out = cmd_in;
    cmd_out.finish = fin;
  end
endmodule
`default_nettype wire

// File: hw/rtl/fraction_arithmetic_unit_top.sv
// Top level of the fraction arithmetic unit.
// Usage: one input item enters on the s_axis channel, carrying an opcode and
// two signed fractions; one result leaves on the m_axis channel.
// The block works on one item at a time. Add, subtract, multiply, divide and
// larger pass through the multiply and finish states from transfer in to
// tvalid out. Reduce adds the subtractive gcd loop, followed by the
// bit-serial divider that divides both sixteen-bit magnitudes by the gcd.
// The result is held in the output register until the receiver takes the
// transfer; a new item is accepted in that same cycle. While the receiver
// stalls, s_axis_tready stays low.
// Reset clears the controller; the datapath registers are not reset.
// Opcodes six and seven return zero over zero with status one.
`default_nettype none
module fraction_arithmetic_unit_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0], a_num[18:3], a_den[34:19], b_num[50:35], b_den[66:51], zero fill
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // res_num[32:0], res_den[64:33], status[65], zero fill
  output logic [71:0]      m_axis_tdata
);
  fau_pkg::cmd_t  cmd_c, cmd;
  fau_pkg::stat_t stat;
  logic [32:0] res_num;
  logic [31:0] res_den;
  logic        status;
  logic enter_done;

  fau_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .stat(stat), .cmd(cmd_c)
  );

  assign enter_done = cmd_c.mul & ~stat.is_reduce | (cmd_c.div_step & stat.div_done);

  fau_result u_res (
    .clk(clk), .rst(rst), .cmd_in(cmd_c), .enter_done(enter_done), .cmd_out(cmd)
  );

  fau_datapath u_dp (
    .clk(clk), .cmd(cmd), .stat(stat),
    .opcode(s_axis_tdata[2:0]),
    .a_num(s_axis_tdata[18:3]), .a_den(s_axis_tdata[34:19]),
    .b_num(s_axis_tdata[50:35]), .b_den(s_axis_tdata[66:51]),
    .res_num(res_num), .res_den(res_den), .status(status)
  );

  assign m_axis_tdata = {6'd0, status, res_den, res_num};

`include "assert_macros.svh"
  `ASSERT_IMPL(a_no_accept_busy, clk, rst, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
  `ASSERT_IMPL(a_out_holds, clk, rst, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  `ASSERT_RST(a_reset_idle, clk, rst |=> !m_axis_tvalid)
endmodule
`default_nettype wire

// File: sim/fraction_arithmetic_unit_top_tb.sv
// Self-checking testbench for the fraction arithmetic unit, with directed and random transfers.
`default_nettype none
module fraction_arithmetic_unit_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT = 300000000;
  localparam int DRAIN_CYCLES = 100;

  typedef struct {
    logic [2:0] op;
    logic signed [15:0] an;
    logic signed [15:0] ad;
    logic signed [15:0] bn;
    logic signed [15:0] bd;
  } operands_t;

  typedef struct {
    logic [32:0] num;
    logic [31:0] den;
    logic st;
  } fraction_t;

  typedef struct {
    operands_t x;
    bit known;
    fraction_t r;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  fraction_t pending_fractions[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  bit hold_off = 1'b0;
  bit steady = 1'b0;

  fraction_arithmetic_unit_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic fraction_t fraction_result(operands_t x);
    longint an, ad, bn, bd, rn, rd, p, q, t, pan, pad, pbn, pbd;
    fraction_t f;
    an = x.an; ad = x.ad; bn = x.bn; bd = x.bd;
    rn = 0; rd = 0; f.st = 1'b0;
    case (x.op)
      fau_pkg::OP_ADD: begin rn = an * bd + ad * bn; rd = ad * bd; end
      fau_pkg::OP_SUB: begin rn = an * bd - ad * bn; rd = ad * bd; end
      fau_pkg::OP_MUL: begin rn = an * bn; rd = ad * bd; end
      fau_pkg::OP_DIV: begin rn = an * bd; rd = ad * bn; end
      fau_pkg::OP_RED: begin
        p = an < 0 ? -an : an;
        q = ad < 0 ? -ad : ad;
        while (q != 0) begin
          t = p % q; p = q; q = t;
        end
        if (p == 0) f.st = 1'b1;
        else begin rn = an / p; rd = ad / p; end
      end
      fau_pkg::OP_MAX: begin
        pan = ad < 0 ? -an : an; pad = ad < 0 ? -ad : ad;
        pbn = bd < 0 ? -bn : bn; pbd = bd < 0 ? -bd : bd;
        if (pan * pbd > pbn * pad) begin rn = an; rd = ad; end
        else begin rn = bn; rd = bd; end
      end
      default: f.st = 1'b1;
    endcase
    f.num = rn[32:0];
    f.den = rd[31:0];
    if (f.den == '0) f.st = 1'b1;
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s at cycle %0d: got %0h, expected %0h", what, cycles, got, want);
    errors++;
  endtask

  function automatic logic signed [15:0] random_operand(bit narrow);
    logic signed [15:0] v;
    case ($urandom_range(19))
      0: v = 16'sh8000;
      1: v = 16'sh7fff;
      2: v = '0;
      default: begin
        if (narrow) v = 16'($urandom_range(300));
        else v = 16'($urandom);
        if (narrow && $urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic send_item(operands_t x, bit known, fraction_t r);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {5'b0, x.bd, x.bn, x.ad, x.an, x.op};
    do @(posedge clk); while (!s_axis_tready);
    pending_fractions.push_back(known ? r : fraction_result(x));
    sent++;
    while (!steady && $urandom_range(99) < 32) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
    end
  endtask

  always @(negedge clk) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || $urandom_range(99) >= 32;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    fraction_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_fractions.size() == 0) begin
        report_mismatch("unexpected transfer", 64'(m_axis_tdata[63:0]), 0);
      end else begin
        want = pending_fractions.pop_front();
        if (m_axis_tdata[32:0] !== want.num)
          report_mismatch("res_num", 64'(m_axis_tdata[32:0]), 64'(want.num));
        if (m_axis_tdata[64:33] !== want.den)
          report_mismatch("res_den", 64'(m_axis_tdata[64:33]), 64'(want.den));
        if (m_axis_tdata[65] !== want.st)
          report_mismatch("status", 64'(m_axis_tdata[65]), 64'(want.st));
      end
    end
  end

  initial begin
    wait (sent == 400);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    row_t rows[$];
    operands_t x;
    fraction_t none;
    int k;
    none = '{num: '0, den: '0, st: 1'b0};
    rows = '{
      '{'{fau_pkg::OP_ADD, 1, 2, 1, 3}, 1, '{33'sd5, 32'sd6, 1'b0}},
      '{'{fau_pkg::OP_SUB, 1, 2, 1, 3}, 1, '{33'sd1, 32'sd6, 1'b0}},
      '{'{fau_pkg::OP_MUL, 2, 3, 5, 7}, 1, '{33'sd10, 32'sd21, 1'b0}},
      '{'{fau_pkg::OP_DIV, 1, 2, 0, 3}, 1, '{33'sd3, 32'sd0, 1'b1}},
      '{'{fau_pkg::OP_RED, 0, 0, 4, 5}, 1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{fau_pkg::OP_RED, 0, -5, 1, 1}, 1, '{33'sd0, -32'sd1, 1'b0}},
      '{'{fau_pkg::OP_RED, 6, -4, 1, 1}, 1, '{33'sd3, -32'sd2, 1'b0}},
      '{'{OP_SPARE6, 3, 4, 5, 6}, 1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{OP_SPARE7, -1, -1, -1, -1}, 1, '{33'sd0, 32'sd0, 1'b1}},
      '{'{fau_pkg::OP_MAX, 1, 2, 2, 4}, 1, '{33'sd2, 32'sd4, 1'b0}},
      '{'{fau_pkg::OP_MAX, -1, -2, 1, 3}, 1, '{-33'sd1, -32'sd2, 1'b0}},
      '{'{fau_pkg::OP_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 0, none},
      '{'{fau_pkg::OP_SUB, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}, 0, none},
      '{'{fau_pkg::OP_MUL, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff}, 0, none},
      '{'{fau_pkg::OP_DIV, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000}, 0, none},
      '{'{fau_pkg::OP_ADD, 5, 0, 3, 7}, 0, none},
      '{'{fau_pkg::OP_MAX, 5, 0, 3, 7}, 0, none},
      '{'{fau_pkg::OP_MAX, -3, 0, 3, 0}, 0, none},
      '{'{fau_pkg::OP_RED, 16'sh8000, 1, 0, 0}, 0, none},
      '{'{fau_pkg::OP_RED, 16'sh7fff, 16'sh7ffe, 0, 0}, 0, none},
      '{'{fau_pkg::OP_RED, 16'sh8000, 16'sh8000, 0, 0}, 0, none},
      '{'{fau_pkg::OP_RED, -12, 0, 0, 0}, 0, none}
    };
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[i]) send_item(rows[i].x, rows[i].known, rows[i].r);
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      steady = (k >= 600 && k < 900);
      if (k == 1000) begin
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending_fractions.size() == 0);
      end
      x.op = 3'($urandom_range(7));
      x.an = random_operand(x.op == fau_pkg::OP_RED && $urandom_range(99) != 0);
      x.ad = random_operand(x.op == fau_pkg::OP_RED && $urandom_range(99) != 0);
      x.bn = random_operand(1'b0);
      x.bd = random_operand(1'b0);
      send_item(x, 1'b0, none);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    wait (pending_fractions.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
